/* hw/rtl/afe_pkg.sv */
package afe_pkg;

    localparam int unsigned ANGLE_W     = 10;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned DIGIT_COUNT = 9;
    localparam int unsigned FRAME_LEN   = 13;
    localparam int unsigned IN_DATA_W   = 32;
    localparam int unsigned CNT_W       = 4;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE  = 10'd999;
    localparam logic [BYTE_W-1:0]  START_MARK = 8'h24;
    localparam logic [BYTE_W-1:0]  END_MARK   = 8'h21;
    localparam logic [BYTE_W-1:0]  ASCII_ZERO = 8'h30;
    localparam logic [15:0]        CRC_POLY   = 16'h1021;
    localparam logic [15:0]        CRC_INIT   = 16'hFFFF;

    // frame byte positions
    localparam logic [CNT_W-1:0] POS_START  = 4'd0;
    localparam logic [CNT_W-1:0] POS_CRC_LO = 4'd10;
    localparam logic [CNT_W-1:0] POS_CRC_HI = 4'd11;
    localparam logic [CNT_W-1:0] POS_END    = 4'd12;

    // nine ascii digits, digit 0 is sent first
    typedef logic [DIGIT_COUNT-1:0][BYTE_W-1:0] t_digits;

    // saturate an angle to the printable range
    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] v);
        return (v > MAX_ANGLE) ? MAX_ANGLE : v;
    endfunction

    // crc-16 update with one byte, msb first
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic is_marker(input logic [BYTE_W-1:0] b);
        return (b == START_MARK) || (b == END_MARK);
    endfunction

endpackage

/* hw/rtl/afe_digits.sv */
module afe_digits (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0][afe_pkg::ANGLE_W-1:0]    i_angles,
    output logic                                o_valid,
    input  logic                                i_ready,
    output afe_pkg::t_digits                    o_digits
);

    // stage valids and enables
    logic       r_v1, r_v2, r_v3;
    logic       en1, en2, en3;

    logic [2:0][afe_pkg::ANGLE_W-1:0] r_ang1;
    logic [2:0][3:0]                  r_hun1;
    logic [2:0][3:0]                  r_hun2;
    logic [2:0][6:0]                  r_rem2;
    afe_pkg::t_digits                 r_dig3;

    logic [2:0][afe_pkg::ANGLE_W-1:0] n_ang1;
    logic [2:0][3:0]                  n_hun1;
    logic [2:0][6:0]                  n_rem2;
    afe_pkg::t_digits                 n_dig3;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;
    assign o_digits = r_dig3;

    // hundreds digit by reciprocal multiply, exact below 1000
    always_comb begin
        logic [15:0] prod;
        for (int a = 0; a < 3; a++) begin
            n_ang1[a] = afe_pkg::clamp_angle(i_angles[a]);
            prod      = {6'd0, n_ang1[a]} * 16'd41;
            n_hun1[a] = prod[15:12];
        end
    end

    // remainder below one hundred
    always_comb begin
        logic [10:0] sub;
        for (int a = 0; a < 3; a++) begin
            sub       = {7'd0, r_hun1[a]} * 11'd100;
            n_rem2[a] = 7'(r_ang1[a] - sub[9:0]);
        end
    end

    // tens and ones, then ascii
    always_comb begin
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        for (int a = 0; a < 3; a++) begin
            prod = {8'd0, r_rem2[a]} * 15'd205;
            tens = prod[14:11];
            ones = r_rem2[a] - 7'({3'd0, tens} * 7'd10);
            n_dig3[a*3+0] = afe_pkg::ASCII_ZERO | {4'd0, r_hun2[a]};
            n_dig3[a*3+1] = afe_pkg::ASCII_ZERO | {4'd0, tens};
            n_dig3[a*3+2] = afe_pkg::ASCII_ZERO | {4'd0, ones[3:0]};
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ang1 <= n_ang1;
            r_hun1 <= n_hun1;
        end
        if (en2) begin
            r_hun2 <= r_hun1;
            r_rem2 <= n_rem2;
        end
        if (en3) begin
            r_dig3 <= n_dig3;
        end
    end

endmodule

/* hw/rtl/afe_crc.sv */
module afe_crc (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  afe_pkg::t_digits i_digits,
    output logic             o_valid,
    input  logic             i_ready,
    output afe_pkg::t_digits o_digits,
    output logic [15:0]      o_crc
);

    logic             r_v1, r_v2, r_v3;
    logic             en1, en2, en3;
    afe_pkg::t_digits r_dig1, r_dig2, r_dig3;
    logic [15:0]      r_crc1, r_crc2, r_crc3;
    logic [15:0]      n_crc1, n_crc2, n_crc3;

    assign en3      = !r_v3 || i_ready;
    assign en2      = !r_v2 || en3;
    assign en1      = !r_v1 || en2;
    assign o_ready  = en1;
    assign o_valid  = r_v3;
    assign o_digits = r_dig3;
    assign o_crc    = r_crc3;

    // three digits per stage
    always_comb begin
        n_crc1 = afe_pkg::crc_add_byte(afe_pkg::CRC_INIT, i_digits[0]);
        n_crc1 = afe_pkg::crc_add_byte(n_crc1, i_digits[1]);
        n_crc1 = afe_pkg::crc_add_byte(n_crc1, i_digits[2]);
    end

    always_comb begin
        n_crc2 = afe_pkg::crc_add_byte(r_crc1, r_dig1[3]);
        n_crc2 = afe_pkg::crc_add_byte(n_crc2, r_dig1[4]);
        n_crc2 = afe_pkg::crc_add_byte(n_crc2, r_dig1[5]);
    end

    // last digits, then blank both bytes if either looks like a marker
    always_comb begin
        n_crc3 = afe_pkg::crc_add_byte(r_crc2, r_dig2[6]);
        n_crc3 = afe_pkg::crc_add_byte(n_crc3, r_dig2[7]);
        n_crc3 = afe_pkg::crc_add_byte(n_crc3, r_dig2[8]);
        if (afe_pkg::is_marker(n_crc3[7:0]) || afe_pkg::is_marker(n_crc3[15:8])) begin
            n_crc3 = 16'h0000;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_dig1 <= i_digits;
            r_crc1 <= n_crc1;
        end
        if (en2) begin
            r_dig2 <= r_dig1;
            r_crc2 <= n_crc2;
        end
        if (en3) begin
            r_dig3 <= r_dig2;
            r_crc3 <= n_crc3;
        end
    end

endmodule

/* hw/rtl/afe_serial.sv */
module afe_serial (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  afe_pkg::t_digits            i_digits,
    input  logic [15:0]                 i_crc,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [afe_pkg::BYTE_W-1:0]  o_byte,
    output logic                        o_last
);

    logic                      r_busy;
    logic [afe_pkg::CNT_W-1:0] r_cnt;
    afe_pkg::t_digits          r_dig;
    logic [15:0]               r_crc;
    logic                      at_end;
    logic                      load;

    assign at_end  = (r_cnt == afe_pkg::POS_END);
    assign o_ready = !r_busy || (i_ready && at_end);
    assign load    = i_valid && o_ready;
    assign o_valid = r_busy;
    assign o_last  = at_end;

    // byte select by frame position
    always_comb begin
        case (r_cnt)
            afe_pkg::POS_START:  o_byte = afe_pkg::START_MARK;
            afe_pkg::POS_CRC_LO: o_byte = r_crc[7:0];
            afe_pkg::POS_CRC_HI: o_byte = r_crc[15:8];
            afe_pkg::POS_END:    o_byte = afe_pkg::END_MARK;
            default: begin
                if (r_cnt >= 4'd1 && r_cnt <= 4'd9) begin
                    o_byte = r_dig[4'(r_cnt - 4'd1)];
                end else begin
                    o_byte = afe_pkg::END_MARK;
                end
            end
        endcase
    end

    // frame position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= afe_pkg::POS_START;
        end else if (load) begin
            r_busy <= 1'b1;
            r_cnt  <= afe_pkg::POS_START;
        end else if (r_busy && i_ready) begin
            if (at_end) begin
                r_busy <= 1'b0;
                r_cnt  <= afe_pkg::POS_START;
            end else begin
                r_cnt  <= r_cnt + 4'd1;
            end
        end
    end

    // frame hold register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dig <= i_digits;
            r_crc <= i_crc;
        end
    end

endmodule

/* hw/rtl/ascii_angle_frame_encoder_crc16.sv */
// a word passes the six pipeline stages and the frame hold register; the output
// serializer then sends 13 bytes per word and takes the next as the last is accepted;
// the stages ahead take a new word every cycle unless full and buffer while it works
// reset: synchronous active low i_rst_n clears all valid bits and the byte counter
// payload registers are not reset
module ascii_angle_frame_encoder_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // first_angle[9:0], second_angle[19:10], third_angle[29:20], zero pad [31:30]
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic [2:0][afe_pkg::ANGLE_W-1:0] angles;
    logic                             dig_valid, dig_ready;
    afe_pkg::t_digits                 dig_data;
    logic                             crc_valid, crc_ready;
    afe_pkg::t_digits                 crc_digits;
    logic [15:0]                      crc_value;

    // unpack input word
    assign angles[0] = i_s_axis_tdata[9:0];
    assign angles[1] = i_s_axis_tdata[19:10];
    assign angles[2] = i_s_axis_tdata[29:20];

    // decimal digits
    afe_digits u_digits (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_angles (angles),
        .o_valid  (dig_valid),
        .i_ready  (dig_ready),
        .o_digits (dig_data)
    );

    // checksum over the digits
    afe_crc u_crc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dig_valid),
        .o_ready  (dig_ready),
        .i_digits (dig_data),
        .o_valid  (crc_valid),
        .i_ready  (crc_ready),
        .o_digits (crc_digits),
        .o_crc    (crc_value)
    );

    // frame out one byte at a time, 13 bytes per input word
    afe_serial u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (crc_valid),
        .o_ready  (crc_ready),
        .i_digits (crc_digits),
        .i_crc    (crc_value),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_byte   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast)
    );

endmodule

/* verif/afe_frame_model_pkg.sv */
`timescale 1ns / 100ps

// expected frame of the angle encoder, shared by the checker and the stimulus
package afe_frame_model_pkg;

    typedef logic [afe_pkg::DIGIT_COUNT-1:0][afe_pkg::BYTE_W-1:0] t_digit_bytes;
    typedef logic [afe_pkg::FRAME_LEN-1:0][afe_pkg::BYTE_W-1:0]   t_frame_bytes;

    // out of range angles print as the largest one
    function automatic logic [afe_pkg::ANGLE_W-1:0] saturate_angle(
        input logic [afe_pkg::ANGLE_W-1:0] v
    );
        if (v > afe_pkg::MAX_ANGLE) begin
            return afe_pkg::MAX_ANGLE;
        end
        return v;
    endfunction

    // nine zero padded decimal digits, first angle first
    function automatic t_digit_bytes angle_digits(input logic [3*afe_pkg::ANGLE_W-1:0] angles);
        t_digit_bytes d;
        int unsigned  v;
        for (int a = 0; a < 3; a++) begin
            v = 32'(saturate_angle(angles[a*afe_pkg::ANGLE_W +: afe_pkg::ANGLE_W]));
            d[a*3 + 0] = afe_pkg::ASCII_ZERO + 8'(v / 100);
            d[a*3 + 1] = afe_pkg::ASCII_ZERO + 8'((v / 10) % 10);
            d[a*3 + 2] = afe_pkg::ASCII_ZERO + 8'(v % 10);
        end
        return d;
    endfunction

    // ccitt-false crc over the digits, msb first
    function automatic logic [15:0] digits_crc(input t_digit_bytes d);
        logic [15:0] c;
        c = afe_pkg::CRC_INIT;
        for (int k = 0; k < afe_pkg::DIGIT_COUNT; k++) begin
            c = c ^ {d[k], 8'h00};
            for (int b = 0; b < 8; b++) begin
                c = c[15] ? ({c[14:0], 1'b0} ^ afe_pkg::CRC_POLY) : {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic collides_with_marker(input logic [afe_pkg::BYTE_W-1:0] b);
        return (b == afe_pkg::START_MARK) || (b == afe_pkg::END_MARK);
    endfunction

    // whole frame: start mark, digits, crc low and high, end mark
    function automatic t_frame_bytes build_frame(input logic [3*afe_pkg::ANGLE_W-1:0] angles);
        t_frame_bytes f;
        t_digit_bytes d;
        logic [15:0]  crc;
        logic [7:0]   lo;
        logic [7:0]   hi;
        d   = angle_digits(angles);
        crc = digits_crc(d);
        lo  = crc[7:0];
        hi  = crc[15:8];
        // a crc byte that looks like a marker blanks both crc bytes
        if (collides_with_marker(lo) || collides_with_marker(hi)) begin
            lo = 8'h00;
            hi = 8'h00;
        end
        f[0] = afe_pkg::START_MARK;
        for (int k = 0; k < afe_pkg::DIGIT_COUNT; k++) begin
            f[1 + k] = d[k];
        end
        f[10] = lo;
        f[11] = hi;
        f[12] = afe_pkg::END_MARK;
        return f;
    endfunction

endpackage

/* verif/afe_frame_checker.sv */
`timescale 1ns / 100ps

module afe_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_tvalid,
    input  logic        i_in_tready,
    // first_angle[9:0], second_angle[19:10], third_angle[29:20], zero pad [31:30]
    input  logic [31:0] i_in_tdata,
    input  logic        i_out_tvalid,
    input  logic        i_out_tready,
    // out_byte[7:0]
    input  logic [7:0]  i_out_tdata,
    input  logic        i_out_tlast,
    output int          o_mismatch_count,
    output int          o_bytes_pending
);

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         pos;
    } t_frame_byte;

    t_frame_byte frame_bytes_due[$];
    int          mismatches = 0;

    assign o_mismatch_count = mismatches;

    // compare each output word with the oldest due byte, then queue new frames
    always @(posedge i_clk) begin : check_proc
        afe_frame_model_pkg::t_frame_bytes f;
        t_frame_byte                       due;
        t_frame_byte                       nxt;
        if (!i_rst_n) begin
            frame_bytes_due.delete();
            o_bytes_pending <= 0;
        end else begin
            if (i_out_tvalid && i_out_tready) begin
                if (frame_bytes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none actual %02h last %b",
                             $time, i_out_tdata, i_out_tlast);
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (i_out_tdata !== due.data) begin
                        mismatches++;
                        $display("%0t: byte %0d data, expected %02h actual %02h",
                                 $time, due.pos, due.data, i_out_tdata);
                    end
                    if (i_out_tlast !== due.last) begin
                        mismatches++;
                        $display("%0t: byte %0d tlast, expected %b actual %b",
                                 $time, due.pos, due.last, i_out_tlast);
                    end
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                f = afe_frame_model_pkg::build_frame(i_in_tdata[3*afe_pkg::ANGLE_W-1:0]);
                for (int k = 0; k < afe_pkg::FRAME_LEN; k++) begin
                    nxt.data = f[k];
                    nxt.last = (k == afe_pkg::FRAME_LEN - 1);
                    nxt.pos  = k;
                    frame_bytes_due.insert(frame_bytes_due.size(), nxt);
                end
            end
            o_bytes_pending <= frame_bytes_due.size();
        end
    end

endmodule

/* verif/tb_ascii_angle_frame_encoder_crc16.sv */
`timescale 1ns / 100ps

module tb_ascii_angle_frame_encoder_crc16;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 40;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_tvalid = 1'b0;
    logic        in_tready;
    // first_angle[9:0], second_angle[19:10], third_angle[29:20], zero pad [31:30]
    logic [31:0] in_tdata  = '0;
    logic        out_tvalid;
    logic        out_tready = 1'b0;
    // out_byte[7:0]
    logic [7:0]  out_tdata;
    logic        out_tlast;

    int mismatch_count;
    int bytes_pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_cycles = 0;

    ascii_angle_frame_encoder_crc16 dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .i_s_axis_tdata  (in_tdata),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .o_m_axis_tdata  (out_tdata),
        .o_m_axis_tlast  (out_tlast)
    );

    afe_frame_checker chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_tvalid      (in_tvalid),
        .i_in_tready      (in_tready),
        .i_in_tdata       (in_tdata),
        .i_out_tvalid     (out_tvalid),
        .i_out_tready     (out_tready),
        .i_out_tdata      (out_tdata),
        .i_out_tlast      (out_tlast),
        .o_mismatch_count (mismatch_count),
        .o_bytes_pending  (bytes_pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls at random
    always @(posedge clk) begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk) begin
        if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("ascii_angle_frame_encoder_crc16 test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [29:0] pack_angles(input int a, input int b, input int c);
        return {10'(c), 10'(b), 10'(a)};
    endfunction

    // search for angles whose low or high crc byte equals the given marker
    function automatic logic [29:0] find_marker_crc(input logic high_byte,
                                                    input logic [7:0] mark);
        logic [29:0] ang;
        logic [15:0] crc;
        logic [7:0]  b;
        ang = '0;
        for (int tries = 0; tries < 20000; tries++) begin
            ang = pack_angles($urandom_range(0, 999), $urandom_range(0, 999),
                              $urandom_range(0, 999));
            crc = afe_frame_model_pkg::digits_crc(afe_frame_model_pkg::angle_digits(ang));
            b   = high_byte ? crc[15:8] : crc[7:0];
            if (b == mark) begin
                return ang;
            end
        end
        return ang;
    endfunction

    function automatic int pick_angle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(0, 999);
        end else if (r < 82) begin
            return $urandom_range(1000, 1023);
        end
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 999;
            2: return 1;
            3: return 998;
            4: return 9;
            5: return 10;
            6: return 99;
            default: return 100;
        endcase
    endfunction

    // present one word and hold it until accepted
    task automatic send_angles(input logic [29:0] ang);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_tvalid <= 1'b0;
            @(posedge clk);
        end
        in_tvalid <= 1'b1;
        in_tdata  <= {2'b00, ang};
        @(posedge clk);
        while (!in_tready) begin
            @(posedge clk);
        end
    endtask

    // stop sending and wait for every due byte
    task automatic drain_frames();
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_phase(input int count);
        logic       high_byte;
        logic [7:0] mark;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                high_byte = 1'($urandom_range(0, 1));
                mark      = ($urandom_range(0, 1) == 0) ? afe_pkg::START_MARK
                                                        : afe_pkg::END_MARK;
                send_angles(find_marker_crc(high_byte, mark));
            end else begin
                send_angles(pack_angles(pick_angle(), pick_angle(), pick_angle()));
            end
            // one pause mid phase until all frames are out
            if (n == count / 2) begin
                drain_frames();
            end
        end
        drain_frames();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles lightly, receiver heavily
        tx_idle_pct = 26;
        rx_idle_pct = 81;

        // directed: range ends, saturation, bit patterns, crc marker collisions
        send_angles(pack_angles(0, 0, 0));
        send_angles(pack_angles(999, 999, 999));
        send_angles(pack_angles(1000, 1023, 1000));
        send_angles(pack_angles(1023, 0, 999));
        send_angles(pack_angles(1, 10, 100));
        send_angles(pack_angles(123, 456, 789));
        send_angles(pack_angles(998, 1001, 5));
        send_angles(pack_angles(341, 682, 1023));
        send_angles(pack_angles(682, 341, 0));
        send_angles(pack_angles(512, 256, 128));
        send_angles(find_marker_crc(1'b0, afe_pkg::START_MARK));
        send_angles(find_marker_crc(1'b0, afe_pkg::END_MARK));
        send_angles(find_marker_crc(1'b1, afe_pkg::START_MARK));
        send_angles(find_marker_crc(1'b1, afe_pkg::END_MARK));
        drain_frames();

        send_random_phase(PHASE_ITEMS);

        // sender idles heavily, receiver lightly
        tx_idle_pct = 81;
        rx_idle_pct = 26;
        send_random_phase(PHASE_ITEMS);

        // back to back, no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_phase(PHASE_ITEMS);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && bytes_pending == 0) begin
            $display("ascii_angle_frame_encoder_crc16 test passed");
        end else begin
            $display("ascii_angle_frame_encoder_crc16 test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/afe_pkg.sv
hw/rtl/afe_digits.sv
hw/rtl/afe_crc.sv
hw/rtl/afe_serial.sv
hw/rtl/ascii_angle_frame_encoder_crc16.sv
verif/afe_frame_model_pkg.sv
verif/afe_frame_checker.sv
verif/tb_ascii_angle_frame_encoder_crc16.sv
